/* rtl/cmf_pkg.sv */
// Shared types, constants and the byte-wide CRC-32 step for the message framer.
// No dependencies; imported by crc32_message_framer_core.
package cmf_pkg;

    localparam int          BUFFER_BYTES = 512;
    localparam int          LEN_CAP      = BUFFER_BYTES - 10;

    localparam logic [7:0]  SYNC_FIRST   = 8'hA5;
    localparam logic [7:0]  SYNC_SECOND  = 8'hFF;
    localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [9:0]  MIN_LEN_FIELD = 10'd4;

    localparam logic [15:0] TYPE_RESET   = 16'h3002;
    localparam logic [8:0]  LENGTH_RESET = 9'd32;

    typedef logic [0:0] reg_index_t;
    localparam reg_index_t REG_MESSAGE_TYPE   = 1'b0;
    localparam reg_index_t REG_PAYLOAD_LENGTH = 1'b1;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  data);
        logic [31:0] crc;
        crc = crc_in ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            crc = (crc >> 1) ^ (crc[0] ? CRC_POLY : 32'd0);
        end
        return crc;
    endfunction

endpackage

/* rtl/crc32_message_framer_core.sv */
// Byte-serial message framer: sync/length/type header, payload, CRC-32 trailer.
// Depends on cmf_pkg for constants and the CRC byte step.
//
// Usage:
//   s_* channel carries payload bytes, one beat per byte. m_* channel carries
//   the framed stream one byte per beat; m_frame_end marks the last CRC byte.
//   cfg_* channel writes message_type (index 0) and payload_length (index 1);
//   it is always ready and must only be used while the framer is idle.
//   The first payload byte of a frame is taken at once and followed on the
//   output by six header bytes, then the byte itself. Mid-frame bytes pass
//   through the output register at one byte per cycle unless m_ready is low.
//   The last byte of a frame adds four CRC beats, during which s_ready stays
//   low. The single output byte register sets throughput: one output byte
//   per cycle if m_ready is high; a frame of N payload bytes is N + 10 bytes.
//   Reset clears the frame position, the CRC and the output valid, and
//   restores message_type 0x3002 and payload_length 32.
//   When the receiver stalls, the output beat holds and s_ready drops.
module crc32_message_framer_core (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  cmf_pkg::reg_index_t      cfg_index,
    input  logic [15:0]              cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [7:0]               s_payload_byte,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [7:0]               m_frame_byte,
    output logic                     m_frame_end
);
    import cmf_pkg::*;

    typedef enum logic [1:0] {ST_PAY, ST_HDR, ST_CRC} state_t;

    localparam logic [8:0] LEN_MAX = (LEN_CAP > 511) ? 9'd511 : 9'(LEN_CAP);

    state_t      state_reg, state_next;
    logic [2:0]  step_reg, step_next;
    logic [8:0]  pos_reg, pos_next;
    logic [31:0] crc_reg, crc_next;
    logic [7:0]  hold_reg, hold_next;
    logic [15:0] type_reg, type_next;
    logic [8:0]  length_reg, length_next;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_byte_reg, m_byte_next;
    logic        m_end_reg, m_end_next;

    logic        out_load;
    logic [8:0]  len_eff;
    logic [9:0]  len_field;
    logic [47:0] hdr_vec;
    logic [7:0]  hdr_byte;
    logic [7:0]  crc_out_byte;
    logic        emit, emit_end, into_crc, pay_go;
    logic [7:0]  emit_byte, pay_byte;
    logic [31:0] crc_base;
    logic [8:0]  pos_inc;

    always_comb begin
        if (length_reg == 9'd0) begin
            len_eff = 9'd1;
        end else if (length_reg > LEN_MAX) begin
            len_eff = LEN_MAX;
        end else begin
            len_eff = length_reg;
        end
        len_field = {1'b0, len_eff} + 10'd2;
        if (len_field <= MIN_LEN_FIELD) begin
            len_field = MIN_LEN_FIELD;
        end
    end

    assign hdr_vec      = {type_reg, 6'd0, len_field, SYNC_SECOND, SYNC_FIRST};
    assign hdr_byte     = hdr_vec[{step_reg, 3'b000} +: 8];
    assign crc_out_byte = crc_reg[{step_reg[1:0], 3'b000} +: 8];
    assign out_load     = !m_valid_reg || m_ready;
    assign s_ready      = out_load && (state_reg == ST_PAY);
    assign cfg_ready    = 1'b1;

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        pos_next     = pos_reg;
        crc_next     = crc_reg;
        hold_next    = hold_reg;
        type_next    = type_reg;
        length_next  = length_reg;
        m_valid_next = m_valid_reg;
        m_byte_next  = m_byte_reg;
        m_end_next   = m_end_reg;
        emit         = 1'b0;
        emit_end     = 1'b0;
        into_crc     = 1'b1;
        pay_go       = 1'b0;
        emit_byte    = hdr_byte;
        pay_byte     = s_payload_byte;
        crc_base     = crc_reg;
        pos_inc      = pos_reg + 9'd1;

        if (cfg_valid) begin
            case (cfg_index)
                REG_MESSAGE_TYPE:   type_next   = cfg_wdata;
                REG_PAYLOAD_LENGTH: length_next = cfg_wdata[8:0];
                default:            type_next   = type_reg;
            endcase
        end

        case (state_reg)
            ST_PAY: begin
                if (s_valid && out_load) begin
                    if (pos_reg == 9'd0) begin
                        hold_next  = s_payload_byte;
                        emit       = 1'b1;
                        emit_byte  = SYNC_FIRST;
                        crc_base   = CRC_INIT;
                        step_next  = 3'd1;
                        state_next = ST_HDR;
                    end else begin
                        pay_go = 1'b1;
                    end
                end
            end
            ST_HDR: begin
                if (out_load) begin
                    if (step_reg == 3'd6) begin
                        pay_go   = 1'b1;
                        pay_byte = hold_reg;
                    end else begin
                        emit      = 1'b1;
                        emit_byte = hdr_byte;
                        step_next = step_reg + 3'd1;
                    end
                end
            end
            ST_CRC: begin
                if (out_load) begin
                    emit      = 1'b1;
                    emit_byte = crc_out_byte;
                    into_crc  = 1'b0;
                    step_next = step_reg + 3'd1;
                    if (step_reg == 3'd3) begin
                        emit_end   = 1'b1;
                        state_next = ST_PAY;
                        crc_next   = CRC_INIT;
                    end
                end
            end
            default: state_next = ST_PAY;
        endcase

        if (pay_go) begin
            emit      = 1'b1;
            emit_byte = pay_byte;
            if (pos_inc >= len_eff) begin
                state_next = ST_CRC;
                step_next  = 3'd0;
                pos_next   = 9'd0;
            end else begin
                state_next = ST_PAY;
                pos_next   = pos_inc;
            end
        end

        if (emit && into_crc) begin
            crc_next = crc32_byte(crc_base, emit_byte);
        end

        if (out_load) begin
            m_valid_next = emit;
            m_byte_next  = emit_byte;
            m_end_next   = emit_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_PAY;
            step_reg    <= 3'd0;
            pos_reg     <= 9'd0;
            crc_reg     <= CRC_INIT;
            type_reg    <= TYPE_RESET;
            length_reg  <= LENGTH_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            pos_reg     <= pos_next;
            crc_reg     <= crc_next;
            type_reg    <= type_next;
            length_reg  <= length_next;
            m_valid_reg <= m_valid_next;
        end
        hold_reg   <= hold_next;
        m_byte_reg <= m_byte_next;
        m_end_reg  <= m_end_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_frame_byte = m_byte_reg;
    assign m_frame_end  = m_end_reg;

    a_pos_only_in_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (pos_reg != 9'd0) |-> (state_reg == ST_PAY))
        else $error("frame position set outside payload phase");

    a_hdr_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HDR) |-> (step_reg >= 3'd1 && step_reg <= 3'd6))
        else $error("header step out of range");

    a_crc_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CRC) |-> (step_reg <= 3'd3))
        else $error("trailer step out of range");

    a_end_after_trailer: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CRC && out_load && step_reg == 3'd3)
        |=> (m_valid_reg && m_end_reg && state_reg == ST_PAY && crc_reg == CRC_INIT))
        else $error("last trailer beat not marked as frame end");

    a_no_end_midframe: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_CRC && out_load) |=> !m_end_reg)
        else $error("frame end raised outside trailer");

endmodule
